// ----- hdl/dlmc_pkg.sv -----
`timescale 1ns / 1ps

package dlmc_pkg;

    // LED pattern bits: bit 0 red, bit 1 yellow, bit 2 green
    typedef logic [2:0] t_led_pat;
    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_cfg_idx;

    localparam int unsigned CNT_W = 16;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_MAX = {CNT_W{1'b1}};

    localparam t_led_pat PAT_OFF    = 3'b000;
    localparam t_led_pat PAT_RED    = 3'b001;
    localparam t_led_pat PAT_YELLOW = 3'b010;
    localparam t_led_pat PAT_GREEN  = 3'b100;
    localparam t_led_pat PAT_ALL    = 3'b111;

    localparam t_mode MODE_OFF     = 2'd0;
    localparam t_mode MODE_TRAFFIC = 2'd1;
    localparam t_mode MODE_STROBE  = 2'd2;
    localparam t_mode MODE_SOLID   = 2'd3;

    localparam logic [1:0] STEP_RED    = 2'd0;
    localparam logic [1:0] STEP_YELLOW = 2'd1;
    localparam logic [1:0] STEP_GREEN  = 2'd2;
    localparam logic [1:0] STEP_SPARE  = 2'd3;

    localparam t_cfg_idx REG_DEBOUNCE_LIMIT = 2'd0;
    localparam t_cfg_idx REG_TRAFFIC_PERIOD = 2'd1;
    localparam t_cfg_idx REG_STROBE_PERIOD  = 2'd2;

    localparam t_cnt RST_DEBOUNCE_LIMIT = 16'd50;
    localparam t_cnt RST_TRAFFIC_PERIOD = 16'd800;
    localparam t_cnt RST_STROBE_PERIOD  = 16'd100;

    // saturating increment
    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + t_cnt'(1);
    endfunction

endpackage

// ----- hdl/debounced_led_mode_controller_unit.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+---------------------------------
// in       | sink      | i_in_valid / o_in_stall      | i_button_raw
// out      | source    | o_out_valid / i_out_stall    | o_led_red/yellow/green, o_mode_now,
//          |           |                              | o_press_seen
// cfg      | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One tick word per cycle while no held result is stalled: each accepted word
// updates every state register in the same cycle and loads the result word. The
// critical path runs from the 16-bit debounce counter increment through the limit
// compare and the press into the period compare.
// Synchronous active-low reset returns the mode to off with all LEDs dark, the
// button to released, and the registers to their default limits.
// A stalled result word holds; the input stalls only while a held result is
// stalled, so a result taken in the same cycle frees the slot for the next word.

module debounced_led_mode_controller_unit
    import dlmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_button_raw,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_led_red,
    output logic        o_led_yellow,
    output logic        o_led_green,
    output logic [1:0]  o_mode_now,
    output logic        o_press_seen,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    t_cnt r_debounce_limit;
    t_cnt r_traffic_period;
    t_cnt r_strobe_period;

    // tick state
    t_mode      r_mode,       n_mode;
    logic       r_last_raw,   n_last_raw;
    logic       r_stable,     n_stable;
    t_cnt       r_deb_cnt,    n_deb_cnt;
    t_cnt       r_phase_cnt,  n_phase_cnt;
    logic [1:0] r_step,       n_step;
    logic       r_strobe_on,  n_strobe_on;
    t_led_pat   r_pattern,    n_pattern;

    // result word
    logic       r_out_valid;
    logic       r_press,      n_press;

    logic       in_accept;
    logic       out_take;

    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // The result word is the state after the tick; state moves only when a
    // new result loads, so the state registers double as the result payload.
    assign o_out_valid  = r_out_valid;
    assign o_led_red    = r_pattern[0];
    assign o_led_yellow = r_pattern[1];
    assign o_led_green  = r_pattern[2];
    assign o_mode_now   = r_mode;
    assign o_press_seen = r_press;

    // Per-tick update: debounce, press, mode entry, periodic pattern step.
    always_comb begin
        n_mode      = r_mode;
        n_stable    = r_stable;
        n_step      = r_step;
        n_strobe_on = r_strobe_on;
        n_pattern   = r_pattern;
        n_press     = 1'b0;
        n_last_raw  = i_button_raw;

        n_phase_cnt = sat_inc(r_phase_cnt);

        // restart the hold counter on any raw edge
        if (i_button_raw != r_last_raw) begin
            n_deb_cnt = '0;
        end else begin
            n_deb_cnt = sat_inc(r_deb_cnt);
        end

        // accept the level once it has held past the limit; a fall is a press
        if ((n_deb_cnt > r_debounce_limit) && (i_button_raw != r_stable)) begin
            n_stable = i_button_raw;
            n_press  = !i_button_raw;
        end

        // advance the mode and apply its entry pattern
        if (n_press) begin
            n_mode      = r_mode + t_mode'(1);
            n_phase_cnt = '0;
            n_step      = STEP_RED;
            n_strobe_on = 1'b0;
            case (n_mode)
                MODE_OFF:     n_pattern = PAT_OFF;
                MODE_TRAFFIC: n_pattern = PAT_RED;
                MODE_STROBE: begin
                    n_pattern   = PAT_ALL;
                    n_strobe_on = 1'b1;
                end
                default:      n_pattern = PAT_ALL;
            endcase
        end

        // periodic step; after a press it fires only for a zero period
        if (n_mode == MODE_TRAFFIC) begin
            if (n_phase_cnt >= r_traffic_period) begin
                n_phase_cnt = '0;
                case (n_step)
                    STEP_RED: begin
                        n_step    = STEP_YELLOW;
                        n_pattern = PAT_YELLOW;
                    end
                    STEP_YELLOW: begin
                        n_step    = STEP_GREEN;
                        n_pattern = PAT_GREEN;
                    end
                    STEP_GREEN: begin
                        n_step    = STEP_RED;
                        n_pattern = PAT_RED;
                    end
                    default: begin
                        // spare step wraps onto yellow
                        n_step    = STEP_YELLOW;
                        n_pattern = PAT_YELLOW;
                    end
                endcase
            end
        end else if (n_mode == MODE_STROBE) begin
            if (n_phase_cnt >= r_strobe_period) begin
                n_phase_cnt = '0;
                n_strobe_on = !n_strobe_on;
                n_pattern   = n_strobe_on ? PAT_ALL : PAT_OFF;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= RST_DEBOUNCE_LIMIT;
            r_traffic_period <= RST_TRAFFIC_PERIOD;
            r_strobe_period  <= RST_STROBE_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_data;
                REG_TRAFFIC_PERIOD: r_traffic_period <= i_cfg_data;
                REG_STROBE_PERIOD:  r_strobe_period  <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // tick state and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_last_raw  <= 1'b1;
            r_stable    <= 1'b1;
            r_deb_cnt   <= '0;
            r_phase_cnt <= '0;
            r_step      <= STEP_RED;
            r_strobe_on <= 1'b0;
            r_pattern   <= PAT_OFF;
            r_press     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_mode      <= n_mode;
                r_last_raw  <= n_last_raw;
                r_stable    <= n_stable;
                r_deb_cnt   <= n_deb_cnt;
                r_phase_cnt <= n_phase_cnt;
                r_step      <= n_step;
                r_strobe_on <= n_strobe_on;
                r_pattern   <= n_pattern;
                r_press     <= n_press;
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
